### hw/rtl/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion-to-Euler unit.
package qte_pkg;

  localparam int unsigned CompBits  = 16;  // quaternion component width, Q2.(CompBits-2)
  localparam int unsigned AngleBits = 16;  // output binary angle width
  localparam int unsigned WorkFrac  = 30;  // fraction bits of the working format
  localparam int unsigned SumBits   = 36;  // products and sums in Q30
  localparam int unsigned CordBits  = 38;  // CORDIC x/y datapath
  localparam int unsigned AccBits   = 32;  // CORDIC angle accumulator, full turn = 2^32
  localparam int unsigned SqrtBits  = 2 * WorkFrac + 2;
  localparam int unsigned SqrtSteps = WorkFrac + 1;

  localparam int ProdShift = 2 * (int'(CompBits) - 2) - int'(WorkFrac);
  localparam int unsigned ProdShr = (ProdShift >= 0) ? ProdShift : 0;
  localparam int unsigned ProdShl = (ProdShift < 0) ? -ProdShift : 0;

  localparam int unsigned OutShift = AccBits - AngleBits;
  localparam logic [AccBits-1:0] RoundHalf =
      (OutShift > 0) ? (AccBits'(1) << (OutShift - 1)) : '0;
  localparam logic [AccBits-1:0] HalfTurn = AccBits'(1) << (AccBits - 1);

  localparam logic signed [SumBits-1:0] OneQ = SumBits'(1) <<< WorkFrac;
  localparam logic signed [AngleBits-1:0] QuarterTurn = AngleBits'(1) <<< (AngleBits - 2);
  localparam logic [SqrtBits-1:0] SqrtOne = SqrtBits'(1) << (2 * WorkFrac);

  typedef struct packed {
    logic signed [CompBits-1:0] quat_w;
    logic signed [CompBits-1:0] quat_x;
    logic signed [CompBits-1:0] quat_y;
    logic signed [CompBits-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [AngleBits-1:0] roll_angle;
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic                        pitch_saturated;
  } euler_t;

  // one vector in flight through the CORDIC row
  typedef struct packed {
    logic signed [CordBits-1:0] x;
    logic signed [CordBits-1:0] y;
    logic [AccBits-1:0]         z;
    logic                       zero;
  } cordic_vec_t;

  // partial remainder and root of the digit-by-digit square root
  typedef struct packed {
    logic [SqrtBits-1:0] rem;
    logic [SqrtBits-1:0] root;
  } sqrt_vec_t;

  // terms that ride alongside the square-root row
  typedef struct packed {
    logic signed [SumBits-1:0]   sr;
    logic signed [SumBits-1:0]   cr;
    logic signed [SumBits-1:0]   sy;
    logic signed [SumBits-1:0]   cy;
    logic signed [WorkFrac:0]    sp;
    logic                        sat;
    logic signed [AngleBits-1:0] clamp;
  } side_t;

  // atan(2^-i) as a 32-bit binary angle, rounded
  function automatic logic [AccBits-1:0] atan_angle(input logic [4:0] idx);
    logic [AccBits-1:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/qte_sqrt_cell.sv
// One digit step of the restoring integer square root, registered.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  sqrt_vec_t vec_i,
  input  side_t     side_i,
  output sqrt_vec_t vec_o,
  output side_t     side_o
);

  localparam logic [SqrtBits-1:0] Bit = SqrtBits'(1) << BIT_POS;

  logic [SqrtBits-1:0] trial;
  sqrt_vec_t vec_d, vec_q;
  side_t side_q;

  assign trial = vec_i.root + Bit;

  always_comb begin
    vec_d = vec_i;
    if (vec_i.rem >= trial) begin
      vec_d.rem  = vec_i.rem - trial;
      vec_d.root = (vec_i.root >> 1) + Bit;
    end else begin
      vec_d.root = vec_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign vec_o  = vec_q;
  assign side_o = side_q;

endmodule

### hw/rtl/qte_cordic_cell.sv
// One CORDIC vectoring micro-rotation, registered.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  cordic_vec_t vec_i,
  output cordic_vec_t vec_o
);

  logic signed [CordBits-1:0] dx, dy;
  cordic_vec_t vec_d, vec_q;

  assign dx = $signed(vec_i.y) >>> STEP;
  assign dy = $signed(vec_i.x) >>> STEP;

  always_comb begin
    vec_d = vec_i;
    if (!vec_i.y[CordBits-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + atan_angle(5'(STEP));
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - atan_angle(5'(STEP));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

### hw/rtl/quaternion_to_euler_angles_unit.sv
// Top level: quaternion to ZYX Euler angles, fully pipelined.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------
//  input   | in_valid_i  | in_stall_o  | in_data_i  (quat_t)
//  output  | out_valid_o | out_stall_i | out_data_o (euler_t)
//
// One quaternion per cycle while in_stall_o is low. From input transfer to
// result shown the stages are: input reg, products, sums, pitch square, radicand,
// a 31-cell square-root row, CORDIC setup, CORDIC_STEPS cells, output reg.
// Reset clears only the valid bits; data registers are not reset.
// Output register plus one skid entry: a stalled result does not stop the
// pipe until a second result is waiting; then the whole pipe holds and
// in_stall_o is high until the held result transfers.
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  quat_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output euler_t out_data_o
);

  localparam int unsigned Depth = 5 + SqrtSteps + 1 + CORDIC_STEPS;

  // pipe enable: the whole row advances unless the skid entry is occupied
  logic en, accept;
  logic [Depth-1:0] valid_q;
  logic skid_valid_q, out_valid_q;
  euler_t skid_q, out_q, res;

  assign en     = !skid_valid_q;
  assign accept = in_valid_i && en;

  // stage 0: input register
  quat_t quat_q;

  // stage 1: the nine component products, in Q30
  logic signed [SumBits-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  function automatic logic signed [SumBits-1:0] mul_q30(
    input logic signed [CompBits-1:0] a,
    input logic signed [CompBits-1:0] b
  );
    logic signed [2*CompBits-1:0] p;
    logic signed [SumBits-1:0] e;
    p = a * b;
    e = SumBits'(p);
    return (e >>> ProdShr) <<< ProdShl;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= in_data_i;
      wx_q   <= mul_q30(quat_q.quat_w, quat_q.quat_x);
      yz_q   <= mul_q30(quat_q.quat_y, quat_q.quat_z);
      xx_q   <= mul_q30(quat_q.quat_x, quat_q.quat_x);
      yy_q   <= mul_q30(quat_q.quat_y, quat_q.quat_y);
      wy_q   <= mul_q30(quat_q.quat_w, quat_q.quat_y);
      zx_q   <= mul_q30(quat_q.quat_z, quat_q.quat_x);
      wz_q   <= mul_q30(quat_q.quat_w, quat_q.quat_z);
      xy_q   <= mul_q30(quat_q.quat_x, quat_q.quat_y);
      zz_q   <= mul_q30(quat_q.quat_z, quat_q.quat_z);
    end
  end

  // stage 2: sine/cosine terms and the pitch clamp decision
  side_t sum_d, sum_q;
  logic signed [SumBits-1:0] sp_full;

  always_comb begin
    sp_full     = (wy_q - zx_q) <<< 1;
    sum_d.sr    = (wx_q + yz_q) <<< 1;
    sum_d.cr    = OneQ - ((xx_q + yy_q) <<< 1);
    sum_d.sy    = (wz_q + xy_q) <<< 1;
    sum_d.cy    = OneQ - ((yy_q + zz_q) <<< 1);
    sum_d.sp    = sp_full[WorkFrac:0];
    sum_d.sat   = (sp_full >= OneQ) || (sp_full <= -OneQ);
    sum_d.clamp = (sp_full > 0) ? QuarterTurn : -QuarterTurn;
  end

  // stage 3: s^2 (only meaningful when not clamped, |s| < 1.0)
  side_t side3_q;
  logic signed [2*WorkFrac+1:0] sq_q;

  // stage 4: radicand 1 - s^2 in Q60
  side_t side4_q;
  sqrt_vec_t rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q      <= sum_d;
      side3_q    <= sum_q;
      sq_q       <= sum_q.sp * sum_q.sp;
      side4_q    <= side3_q;
      rad_q.rem  <= SqrtOne - SqrtBits'(sq_q);
      rad_q.root <= '0;
    end
  end

  // square-root row: cos(pitch) = sqrt(1 - s^2), one root bit per cell
  sqrt_vec_t sq_vec [SqrtSteps+1];
  side_t     sq_side [SqrtSteps+1];

  assign sq_vec[0]  = rad_q;
  assign sq_side[0] = side4_q;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    qte_sqrt_cell #(
      .BIT_POS(2 * (SqrtSteps - 1 - k))
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (sq_vec[k]),
      .side_i(sq_side[k]),
      .vec_o (sq_vec[k+1]),
      .side_o(sq_side[k+1])
    );
  end

  // CORDIC setup: fold the left half-plane, flag the all-zero vector
  function automatic cordic_vec_t cordic_init(
    input logic signed [CordBits-1:0] y,
    input logic signed [CordBits-1:0] x
  );
    cordic_vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[CordBits-1]) begin
      v.x = -x;
      v.y = -y;
      v.z = HalfTurn;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  side_t fin_side;
  cordic_vec_t roll_v  [CORDIC_STEPS+1];
  cordic_vec_t pitch_v [CORDIC_STEPS+1];
  cordic_vec_t yaw_v   [CORDIC_STEPS+1];
  logic                        sat_q   [CORDIC_STEPS+1];
  logic signed [AngleBits-1:0] clamp_q [CORDIC_STEPS+1];
  cordic_vec_t roll_init_q, pitch_init_q, yaw_init_q;

  assign fin_side = sq_side[SqrtSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_init_q  <= cordic_init(CordBits'(fin_side.sr), CordBits'(fin_side.cr));
      yaw_init_q   <= cordic_init(CordBits'(fin_side.sy), CordBits'(fin_side.cy));
      pitch_init_q <= cordic_init(CordBits'(fin_side.sp),
                                  $signed(sq_vec[SqrtSteps].root[CordBits-1:0]));
      sat_q[0]     <= fin_side.sat;
      clamp_q[0]   <= fin_side.clamp;
    end
  end

  assign roll_v[0]  = roll_init_q;
  assign pitch_v[0] = pitch_init_q;
  assign yaw_v[0]   = yaw_init_q;

  // CORDIC row: three vectors rotate side by side, one step per cell
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    qte_cordic_cell #(.STEP(s)) u_roll (
      .clk_i(clk_i), .en_i(en), .vec_i(roll_v[s]),  .vec_o(roll_v[s+1])
    );
    qte_cordic_cell #(.STEP(s)) u_pitch (
      .clk_i(clk_i), .en_i(en), .vec_i(pitch_v[s]), .vec_o(pitch_v[s+1])
    );
    qte_cordic_cell #(.STEP(s)) u_yaw (
      .clk_i(clk_i), .en_i(en), .vec_i(yaw_v[s]),   .vec_o(yaw_v[s+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        sat_q[s+1]   <= sat_q[s];
        clamp_q[s+1] <= clamp_q[s];
      end
    end
  end

  // round the 32-bit accumulator to the output angle width (wraps at +pi)
  function automatic logic signed [AngleBits-1:0] to_angle(input cordic_vec_t v);
    logic [AccBits-1:0] a;
    a = v.zero ? '0 : v.z + RoundHalf;
    return $signed(AngleBits'(a >> OutShift));
  endfunction

  always_comb begin
    res.roll_angle      = to_angle(roll_v[CORDIC_STEPS]);
    res.yaw_angle       = to_angle(yaw_v[CORDIC_STEPS]);
    res.pitch_angle     = sat_q[CORDIC_STEPS] ? clamp_q[CORDIC_STEPS]
                                              : to_angle(pitch_v[CORDIC_STEPS]);
    res.pitch_saturated = sat_q[CORDIC_STEPS];
  end

  // output register and skid entry
  logic out_free, last_valid;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_valid = valid_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        valid_q <= {valid_q[Depth-2:0], accept};
      end
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (out_free) begin
        out_valid_q <= last_valid;
      end else if (last_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= res;
    end else if (last_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/qte_checker.sv
// Port-level checks for the quaternion-to-Euler unit, bound to the top level.
module qte_checker import qte_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_stall_o,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input euler_t out_data_o
);

  // a held result keeps its value until it transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input is stalled only while a result is waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a clamped pitch is exactly a quarter turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pitch_saturated |->
      ($signed(out_data_o.pitch_angle) == QuarterTurn) ||
      ($signed(out_data_o.pitch_angle) == -QuarterTurn))
    else $error("clamped pitch not a quarter turn");

  // pitch never leaves the quarter-turn band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($signed(out_data_o.pitch_angle) <= QuarterTurn) &&
      ($signed(out_data_o.pitch_angle) >= -QuarterTurn))
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (.*);

### sim/tb_quaternion_to_euler_angles_unit.sv
// Testbench for the quaternion-to-Euler unit: random and directed quaternions, checked in order.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles_unit;
  import qte_pkg::*;

  localparam int unsigned Steps   = 16;
  localparam int unsigned Latency = 38 + Steps;
  localparam int unsigned NumRand = 1050;
  localparam longint      CycleLimit = 400000;

  // cordic angle increments, rounded binary angles
  localparam logic [31:0] AtanRom [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint p;
    p = a * b;
    if (2 * (CompBits - 2) >= WorkFrac) return floor_shr(p, 2 * (CompBits - 2) - WorkFrac);
    return p <<< (WorkFrac - 2 * (CompBits - 2));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < Steps && i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += AtanRom[i];
      end else begin
        x -= dx;
        y += dy;
        z -= AtanRom[i];
      end
    end
    return z;
  endfunction

  function automatic logic [AngleBits-1:0] narrow_angle(logic [31:0] a);
    if (32 - AngleBits > 0) a += 32'd1 << (32 - AngleBits - 1);
    return AngleBits'(a >> (32 - AngleBits));
  endfunction

  function automatic euler_t euler_of(quat_t q);
    euler_t r;
    longint one, w, x, y, z, sr, cr, sp, sy, cy, c;
    one = 64'sd1 <<< WorkFrac;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    sr = 2 * (mul_q30(w, x) + mul_q30(y, z));
    cr = one - 2 * (mul_q30(x, x) + mul_q30(y, y));
    sp = 2 * (mul_q30(w, y) - mul_q30(z, x));
    sy = 2 * (mul_q30(w, z) + mul_q30(x, y));
    cy = one - 2 * (mul_q30(y, y) + mul_q30(z, z));
    if (sp >= one || sp <= -one) begin
      r.pitch_saturated = 1'b1;
      r.pitch_angle = (sp > 0) ? QuarterTurn : -QuarterTurn;
    end else begin
      r.pitch_saturated = 1'b0;
      c = longint'(int_sqrt((64'd1 << (2 * WorkFrac)) - longint'(sp * sp)));
      r.pitch_angle = narrow_angle(vector_angle(sp, c));
    end
    r.roll_angle = narrow_angle(vector_angle(sr, cr));
    r.yaw_angle  = narrow_angle(vector_angle(sy, cy));
    return r;
  endfunction

  // in-order store of predicted angles
  class euler_scoreboard;
    euler_t pending[$];
    int     errors;

    function void note_quat(quat_t q);
      pending.push_back(euler_of(q));
    endfunction

    function void check_euler(euler_t got);
      euler_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.roll_angle !== exp_r.roll_angle) begin
        $display("%0t: roll expected %0d actual %0d", $time,
                 exp_r.roll_angle, got.roll_angle);
        errors++;
      end
      if (got.pitch_angle !== exp_r.pitch_angle) begin
        $display("%0t: pitch expected %0d actual %0d", $time,
                 exp_r.pitch_angle, got.pitch_angle);
        errors++;
      end
      if (got.yaw_angle !== exp_r.yaw_angle) begin
        $display("%0t: yaw expected %0d actual %0d", $time,
                 exp_r.yaw_angle, got.yaw_angle);
        errors++;
      end
      if (got.pitch_saturated !== exp_r.pitch_saturated) begin
        $display("%0t: pitch_saturated expected %0b actual %0b", $time,
                 exp_r.pitch_saturated, got.pitch_saturated);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  quat_t  in_data_i;
  logic   out_valid_o;
  logic   out_stall_i;
  euler_t out_data_o;

  euler_scoreboard angle_board;
  int     send_idle_pct;   // chance of a sender gap, percent
  int     recv_stall_pct;  // chance of a receiver stall, percent
  longint cycle_count;

  quaternion_to_euler_angles_unit #(.CORDIC_STEPS(Steps)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: sample the transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) angle_board.check_euler(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one input transfer; valid held until accepted, gaps drawn between items
  task automatic send_quat(quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    angle_board.note_quat(q);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom);
  endfunction

  // a roughly unit quaternion, with small random noise; a quarter of them built to lean toward gimbal lock
  function automatic quat_t near_unit_quat();
    quat_t q;
    real a, b, c, d, n;
    a = $urandom_range(65535) / 32768.0 - 1.0;
    b = $urandom_range(65535) / 32768.0 - 1.0;
    c = $urandom_range(65535) / 32768.0 - 1.0;
    d = $urandom_range(65535) / 32768.0 - 1.0;
    if ($urandom_range(3) == 0) begin
      // y ~ +-w, z ~ +-x; with opposite signs 2(wy-zx) goes toward +-1
      c = ($urandom_range(1) ? a : -a);
      d = ($urandom_range(1) ? b : -b);
    end
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 0.01) n = 1.0;
    q.quat_w = 16'($rtoi(a / n * 16384.0) + $signed($urandom_range(8)) - 4);
    q.quat_x = 16'($rtoi(b / n * 16384.0) + $signed($urandom_range(8)) - 4);
    q.quat_y = 16'($rtoi(c / n * 16384.0) + $signed($urandom_range(8)) - 4);
    q.quat_z = 16'($rtoi(d / n * 16384.0) + $signed($urandom_range(8)) - 4);
    return q;
  endfunction

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    quat_t q;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) q = near_unit_quat();
      else q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      send_quat(q);
    end
  endtask

  initial begin
    quat_t dq[$];
    angle_board    = new();
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, half turns, zero vector, clamp both ways, extremes
    dq.push_back('{16384, 0, 0, 0});
    dq.push_back('{0, 16384, 0, 0});
    dq.push_back('{0, 0, 16384, 0});
    dq.push_back('{0, 0, 0, 16384});
    dq.push_back('{-16384, 0, 0, 0});
    dq.push_back('{0, 0, 0, 0});
    dq.push_back('{11585, 0, 11585, 0});
    dq.push_back('{11585, 0, -11585, 0});
    dq.push_back('{11586, 0, 11586, 0});
    dq.push_back('{11585, 11585, 11585, -11585});
    dq.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    dq.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    dq.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    dq.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    dq.push_back('{16'sh8000, 0, 16'sh7fff, 0});
    dq.push_back('{-1, -1, -1, -1});
    dq.push_back('{1, 1, 1, 1});
    dq.push_back('{0, 11585, 0, 11585});
    dq.push_back('{11585, 11585, 0, 0});
    dq.push_back('{11585, 0, 0, -11585});
    send_idle_pct = 10;
    recv_stall_pct = 20;
    foreach (dq[i]) send_quat(dq[i]);

    run_phase(int'(NumRand / 3), 15, 58);
    run_phase(int'(NumRand / 3), 58, 15);
    run_phase(int'(NumRand / 3), 0, 0);
    in_valid_i <= 1'b0;
    recv_stall_pct = 30;
    while (angle_board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    if (angle_board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
